### rtl/core/cfq_pkg.sv
// Shared types and codes for the circular FIFO queue core.
package cfq_pkg;

    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_DISP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } t_cfq_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } t_cfq_rsp;

endpackage

### rtl/core/cfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/circular_fifo_queue_core.sv
// Top level of the circular FIFO queue core: control, pointers and result register.
//
// Usage:
//   A request word (mode, value) is taken at a rising edge with start high and
//   busy low. Modes: enqueue, dequeue, display; the unused mode is dropped
//   without a result.
//   Each result word appears on o_rsp for exactly one cycle with o_valid high.
//   The receiver cannot stall; every result must be taken when shown.
// Results:
//   Enqueue, overflow, underflow and empty display: the result is shown in the
//   cycle after the request; busy stays low, so a request can follow every cycle.
//   Dequeue: the head slot is read through the storage RAM's registered port,
//   then held in the result register; busy is high while the read is under way.
//   Display of N stored words: one RAM read per word, each passing through the
//   RAM's registered port and the result register; the N results follow one per
//   cycle with no gap, and busy is high until the final word has been read.
//   The final word carries last.
// Reset:
//   Synchronous, active low; the queue becomes empty, pointers return to
//   slot zero. Storage contents are not cleared.
module circular_fifo_queue_core #(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  cfq_pkg::t_cfq_req i_req,
    output logic              busy,
    output logic              o_valid,
    output cfq_pkg::t_cfq_rsp o_rsp
);

    import cfq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEQ  = 2'd1;
    localparam logic [1:0] S_DISP = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [PTR_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;
    t_cfq_rsp         r_rsp, n_rsp;

    logic             accept;
    logic             ram_we;
    logic [PTR_W-1:0] ram_raddr;
    logic [31:0]      ram_rdata;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] idx);
        return (idx == PTR_W'(DEPTH - 1)) ? '0 : idx + PTR_W'(1);
    endfunction

    cfq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_req.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_idx     = r_idx;
        n_occ     = r_occ;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_raddr = (r_state == S_DISP) ? r_idx : r_head;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.mode)
                        MODE_ENQ: begin
                            n_valid = 1'b1;
                            n_rsp   = '{status: ST_OK, data: '0, last: 1'b1};
                            if (r_occ == CNT_W'(DEPTH)) begin
                                n_rsp.status = ST_OVERFLOW;
                            end else begin
                                ram_we = 1'b1;
                                n_tail = wrap_next(r_tail);
                                n_occ  = r_occ + CNT_W'(1);
                            end
                        end
                        MODE_DEQ: begin
                            if (r_occ == '0) begin
                                n_valid = 1'b1;
                                n_rsp   = '{status: ST_UNDERFLOW, data: '0, last: 1'b1};
                            end else begin
                                n_head  = wrap_next(r_head);
                                n_occ   = r_occ - CNT_W'(1);
                                n_state = S_DEQ;
                            end
                        end
                        MODE_DISP: begin
                            if (r_occ == '0) begin
                                n_valid = 1'b1;
                                n_rsp   = '{status: ST_EMPTY, data: '0, last: 1'b1};
                            end else begin
                                n_idx   = wrap_next(r_head);
                                n_cnt   = r_occ;
                                n_state = S_DISP;
                            end
                        end
                        default: begin
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_valid = 1'b1;
                n_rsp   = '{status: ST_OK, data: ram_rdata, last: 1'b1};
                n_state = S_IDLE;
            end
            S_DISP: begin
                n_valid = 1'b1;
                n_rsp   = '{status: ST_OK, data: ram_rdata, last: (r_cnt == CNT_W'(1))};
                n_idx   = wrap_next(r_idx);
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_idx   <= '0;
            r_occ   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_idx   <= n_idx;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

### verif/tb_circular_fifo_queue_core.sv
// Testbench for circular_fifo_queue_core: bursty request driver, self-checking result monitor.
module tb_circular_fifo_queue_core;
    import cfq_pkg::*;

    localparam int QDEPTH = 8;
    localparam int N_RANDOM = 280;
    localparam int CYCLE_LIMIT = 100000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic     drain;
        t_cfq_req req;
    } t_req_slot;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    t_cfq_req i_req = '0;
    logic     busy;
    logic     o_valid;
    t_cfq_rsp o_rsp;

    circular_fifo_queue_core #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    t_req_slot   req_words[$];
    t_cfq_rsp    rsp_expected[$];

    logic [31:0] fifo_mem [QDEPTH];
    int          fifo_head = 0;
    int          fifo_tail = 0;
    int          fifo_count = 0;

    int          mismatches = 0;
    int          words_checked = 0;
    int          n_accepted = 0;
    int          n_overflow = 0;
    int          n_underflow = 0;
    int          n_full_disp = 0;
    int          n_wraps = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          cycles = 0;

    function automatic void add_expected(logic [1:0] status, logic [31:0] data, logic last);
        t_cfq_rsp w;
        w.status = status;
        w.data   = data;
        w.last   = last;
        rsp_expected.push_back(w);
    endfunction

    function automatic void fifo_apply(t_cfq_req r);
        int idx;
        case (r.mode)
            MODE_ENQ: begin
                if (fifo_count == QDEPTH) begin
                    n_overflow++;
                    add_expected(ST_OVERFLOW, '0, 1'b1);
                end else begin
                    fifo_mem[fifo_tail] = r.value;
                    fifo_tail = (fifo_tail + 1) % QDEPTH;
                    if (fifo_tail == 0) n_wraps++;
                    fifo_count++;
                    add_expected(ST_OK, '0, 1'b1);
                end
            end
            MODE_DEQ: begin
                if (fifo_count == 0) begin
                    n_underflow++;
                    add_expected(ST_UNDERFLOW, '0, 1'b1);
                end else begin
                    add_expected(ST_OK, fifo_mem[fifo_head], 1'b1);
                    fifo_head = (fifo_head + 1) % QDEPTH;
                    fifo_count--;
                end
            end
            MODE_DISP: begin
                if (fifo_count == 0) begin
                    add_expected(ST_EMPTY, '0, 1'b1);
                end else begin
                    if (fifo_count == QDEPTH) n_full_disp++;
                    idx = fifo_head;
                    for (int i = 0; i < fifo_count; i++) begin
                        add_expected(ST_OK, fifo_mem[idx], (i + 1 == fifo_count));
                        idx = (idx + 1) % QDEPTH;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_req(logic [1:0] mode, logic [31:0] value, logic drain);
        t_req_slot s;
        s.drain      = drain;
        s.req.mode   = mode;
        s.req.value  = value;
        req_words.push_back(s);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            if (start && !busy) begin
                fifo_apply(i_req);
                void'(req_words.pop_front());
                n_accepted++;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                             : $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 5);
                end
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (req_words.size() > 0 &&
                         !(req_words[0].drain && rsp_expected.size() != 0)) begin
                start <= 1'b1;
                i_req <= req_words[0].req;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cfq_rsp w;
        if (i_rst_n && o_valid) begin
            if (rsp_expected.size() == 0) begin
                $error("unexpected result word: status %0d data %0h last %0b",
                       o_rsp.status, o_rsp.data, o_rsp.last);
                mismatches++;
            end else begin
                w = rsp_expected.pop_front();
                words_checked++;
                if (o_rsp.status !== w.status) begin
                    $error("status mismatch: expected %0d, got %0d", w.status, o_rsp.status);
                    mismatches++;
                end
                if (o_rsp.data !== w.data) begin
                    $error("data mismatch: expected %0d, got %0d", w.data, o_rsp.data);
                    mismatches++;
                end
                if (o_rsp.last !== w.last) begin
                    $error("last mismatch: expected %0b, got %0b", w.last, o_rsp.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int          n_real;
        int          bias;
        int          len;
        int          roll;
        int          enq_pct;
        logic [1:0]  mode;

        for (int i = 0; i < QDEPTH; i++) fifo_mem[i] = '0;

        queue_req(MODE_DISP, $urandom, 1'b0);
        queue_req(MODE_DEQ, $urandom, 1'b0);
        queue_req(MODE_ENQ, 32'h8000_0000, 1'b0);
        queue_req(MODE_ENQ, 32'h7FFF_FFFF, 1'b0);
        queue_req(MODE_ENQ, 32'h0000_0000, 1'b0);
        queue_req(MODE_ENQ, 32'hFFFF_FFFF, 1'b0);
        for (int i = 0; i < QDEPTH - 4; i++) queue_req(MODE_ENQ, $urandom, 1'b0);
        queue_req(MODE_ENQ, 32'hA5A5_5A5A, 1'b0);
        queue_req(MODE_DISP, '0, 1'b0);
        queue_req(MODE_UNUSED, 32'hFFFF_FFFF, 1'b0);
        queue_req(MODE_DEQ, '0, 1'b0);
        queue_req(MODE_DEQ, '0, 1'b0);
        queue_req(MODE_ENQ, $urandom, 1'b0);
        queue_req(MODE_ENQ, $urandom, 1'b0);
        queue_req(MODE_DISP, '0, 1'b0);
        queue_req(MODE_UNUSED, '0, 1'b0);

        n_real = 0;
        while (n_real < N_RANDOM) begin
            bias = $urandom_range(0, 2);
            enq_pct = (bias == 0) ? 70 : (bias == 1) ? 25 : 50;
            len = $urandom_range(8, 30);
            for (int k = 0; k < len && n_real < N_RANDOM; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    mode = MODE_UNUSED;
                end else if (roll < 18) begin
                    mode = MODE_DISP;
                end else begin
                    mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
                end
                if (mode != MODE_UNUSED) n_real++;
                queue_req(mode, pick_value(), (n_real == 1) || ($urandom_range(0, 39) == 0));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (req_words.size() == 0 && rsp_expected.size() == 0);
        repeat (12) @(posedge i_clk);

        $display("%0d requests taken, %0d result words checked", n_accepted, words_checked);
        $display("overflows %0d, underflows %0d, full displays %0d, tail wraps %0d",
                 n_overflow, n_underflow, n_full_disp, n_wraps);
        if (mismatches == 0 && rsp_expected.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
